// ----- rtl/core/tpaf_pkg.sv -----
package tpaf_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int MASK_W       = 8;
  localparam int TICK_W       = 8;
  localparam int FUNC_W       = 2;
  localparam int CHAN_W       = 3;
  localparam int CFG_IDX_W    = 1;

  localparam logic [TICK_W-1:0] CUTOFF_RESET    = 8'd95;
  localparam logic [TICK_W-1:0] MIN_CROSS_RESET = 8'd5;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CROSS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELAY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CROSS = 1'd1;

  typedef struct packed {
    logic [MASK_W-1:0] gate_mask;
    logic              sync_lost;
    logic              cross_taken;
  } result_t;

endpackage

// ----- rtl/core/tpaf_core.sv -----
module tpaf_core #(
  parameter int CHANNELS = tpaf_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tpaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpaf_pkg::TICK_W-1:0]    cfg_data,
  input  logic                           take,
  input  logic [tpaf_pkg::FUNC_W-1:0]    func,
  input  logic [tpaf_pkg::CHAN_W-1:0]    channel,
  input  logic [tpaf_pkg::TICK_W-1:0]    delay_ticks,
  output tpaf_pkg::result_t              res
);
  import tpaf_pkg::*;

  localparam int GATE_N = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  logic [TICK_W-1:0] cutoff_tick;
  logic [TICK_W-1:0] min_cross_interval;
  logic [TICK_W-1:0] phase_count;
  logic [TICK_W-1:0] phase_count_next;
  logic              lost;
  logic              lost_next;
  logic [TICK_W-1:0] channel_delay [CHANNELS];
  logic [TICK_W:0]   tick_sum;
  logic              over;
  logic              cross_ok;
  logic [MASK_W-1:0] gates;

  // 9-bit increment so a count of 255 still overruns the cutoff
  assign tick_sum = {1'b0, phase_count} + {{TICK_W{1'b0}}, 1'b1};
  assign over     = tick_sum > {1'b0, cutoff_tick};
  assign cross_ok = phase_count >= min_cross_interval;

  always_comb begin
    gates = '0;
    for (int c = 0; c < GATE_N; c++) begin
      gates[c] = {1'b0, channel_delay[c]} <= tick_sum;
    end
  end

  always_comb begin
    phase_count_next = phase_count;
    lost_next        = lost;
    res.gate_mask    = '0;
    res.cross_taken  = 1'b0;
    case (func)
      FUNC_TICK: begin
        if (over) begin
          phase_count_next = cutoff_tick;
          lost_next        = 1'b1;
        end else begin
          phase_count_next = tick_sum[TICK_W-1:0];
          res.gate_mask    = gates;
        end
      end
      FUNC_CROSS: begin
        if (cross_ok) begin
          phase_count_next = '0;
          lost_next        = 1'b0;
          res.cross_taken  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.sync_lost = lost_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_tick        <= CUTOFF_RESET;
      min_cross_interval <= MIN_CROSS_RESET;
      phase_count        <= '0;
      lost               <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        channel_delay[c] <= CUTOFF_RESET;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CUTOFF:    cutoff_tick        <= cfg_data;
          CFG_MIN_CROSS: min_cross_interval <= cfg_data;
          default: begin
          end
        endcase
      end
      if (take) begin
        phase_count <= phase_count_next;
        lost        <= lost_next;
        if (func == FUNC_DELAY) begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (int'(channel) == c) begin
              channel_delay[c] <= delay_ticks;
            end
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/tpaf_out_buf.sv -----
module tpaf_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tpaf_pkg::result_t push_data,
  output logic              room,
  output logic              valid,
  input  logic              ready,
  output tpaf_pkg::result_t data
);
  import tpaf_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    pop;

  assign pop  = valid && ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid entry first; no push can arrive while it is full
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!valid || pop) begin
        valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        data <= skid;
      end
    end else if (push) begin
      if (!valid || pop) begin
        data <= push_data;
      end else begin
        skid <= push_data;
      end
    end
  end

endmodule

// ----- rtl/core/triac_phase_angle_firing_unit.sv -----
// Eight-channel phase-angle triac firing unit. Each input transaction is a
// timer tick, a mains zero crossing or a per-channel delay write, and each
// produces exactly one result transaction: the gate mask for this tick, the
// sticky sync-lost flag and whether a zero crossing was taken. A transaction
// is accepted every cycle: the counter, the flag and all channel compares
// update in one pass, and the result lands in a two-entry output buffer, so
// in_ready drops only when both entries hold results the consumer has not
// taken. Registers cutoff_tick (index 0, reset 95) and min_cross_interval
// (index 1, reset 5) are written through cfg_write/cfg_index/cfg_data; the
// user must write them only while idle, which the unit does not enforce.
module triac_phase_angle_firing_unit #(
  parameter int CHANNELS = tpaf_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tpaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpaf_pkg::TICK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tpaf_pkg::FUNC_W-1:0]    func,
  input  logic [tpaf_pkg::CHAN_W-1:0]    channel,
  input  logic [tpaf_pkg::TICK_W-1:0]    delay_ticks,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tpaf_pkg::MASK_W-1:0]    gate_mask,
  output logic                           sync_lost,
  output logic                           cross_taken
);
  import tpaf_pkg::*;

  logic    take;
  result_t res;
  result_t out_data;

  assign take = in_valid && in_ready;

  tpaf_core #(
    .CHANNELS(CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .func       (func),
    .channel    (channel),
    .delay_ticks(delay_ticks),
    .res        (res)
  );

  tpaf_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_data(res),
    .room     (in_ready),
    .valid    (out_valid),
    .ready    (out_ready),
    .data     (out_data)
  );

  assign gate_mask   = out_data.gate_mask;
  assign sync_lost   = out_data.sync_lost;
  assign cross_taken = out_data.cross_taken;

endmodule

// ----- rtl/core/tpaf_checker.sv -----
module tpaf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tpaf_pkg::MASK_W-1:0] gate_mask,
  input logic                        sync_lost,
  input logic                        cross_taken
);
  import tpaf_pkg::*;

  // a taken crossing always clears the lost flag
  a_cross_clears_lost: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(cross_taken && sync_lost))
    else $error("cross_taken reported with sync_lost set");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("in_ready low right after reset");

  // input backpressure only when results are waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gate_mask)
      && $stable(sync_lost) && $stable(cross_taken))
    else $error("stalled result changed");

endmodule

bind triac_phase_angle_firing_unit tpaf_checker u_tpaf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .gate_mask  (gate_mask),
  .sync_lost  (sync_lost),
  .cross_taken(cross_taken)
);
